[sv/stoi_pkg.sv]
// shared widths, codes and character constants for the string-to-integer parser
package stoi_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  typedef logic [CH_W-1:0]       ch_t;
  typedef logic [VALUE_W-1:0]    value_t;
  typedef logic [STATUS_W-1:0]   status_t;
  typedef logic [RADIX_W-1:0]    radix_t;
  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MALFORMED = 2'd1;
  localparam status_t ST_RANGE     = 2'd2;

  // target kinds
  localparam kind_t KIND_S32 = 2'd0;
  localparam kind_t KIND_S64 = 2'd1;
  localparam kind_t KIND_U32 = 2'd2;
  localparam kind_t KIND_U64 = 2'd3;

  // configuration register indexes
  localparam cfg_idx_t REG_RADIX = 2'd0;
  localparam cfg_idx_t REG_KIND  = 2'd1;

  localparam radix_t RADIX_RESET = 6'd10;
  localparam kind_t  KIND_RESET  = KIND_S64;

  // characters
  localparam ch_t CH_NUL   = 8'h00;
  localparam ch_t CH_PLUS  = 8'h2B;
  localparam ch_t CH_MINUS = 8'h2D;
  localparam ch_t CH_ZERO  = 8'h30;
  localparam ch_t CH_NINE  = 8'h39;
  localparam ch_t CH_UA    = 8'h41;
  localparam ch_t CH_UX    = 8'h58;
  localparam ch_t CH_UZ    = 8'h5A;
  localparam ch_t CH_LA    = 8'h61;
  localparam ch_t CH_LX    = 8'h78;
  localparam ch_t CH_LZ    = 8'h7A;

endpackage

[sv/stoi_if.sv]
// valid/ready channel interfaces for characters, results and register writes

interface stoi_in_if;
  logic          valid;
  logic          ready;
  stoi_pkg::ch_t ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface stoi_out_if;
  logic              valid;
  logic              ready;
  stoi_pkg::value_t  parsed_value;
  stoi_pkg::status_t status;

  modport source (output valid, output parsed_value, output status, input ready);
  modport sink   (input valid, input parsed_value, input status, output ready);
endinterface

interface stoi_cfg_if;
  logic                valid;
  logic                ready;
  stoi_pkg::cfg_idx_t  idx;
  stoi_pkg::cfg_data_t data;

  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

[sv/string_to_integer_parser.sv]
// streaming ascii string to integer parser, one character per word
//
//   channel   dir  payload                       accepted when
//   in_chan   in   ch[7:0]                       valid && ready
//   out_chan  out  parsed_value[63:0] status[1:0] valid && ready
//   cfg_chan  in   idx[1:0] data[7:0]            valid && ready (ready always high)
//
// one character word per cycle unless a terminator waits on a held result; the
// loop through the running magnitude is one 64x6 multiply plus digit add and
// overflow check, which sets that rate; a character passes through the input
// register, and a terminator's result then goes to the output register
// synchronous active-low reset clears the parse state, radix to 10 and kind to
// signed 64; a waiting result stalls only a terminator, other characters flow on
module string_to_integer_parser (
  input  logic          clk,
  input  logic          rst_n,
  stoi_in_if.sink       in_chan,
  stoi_out_if.source    out_chan,
  stoi_cfg_if.sink      cfg_chan
);

  // parse phases
  localparam logic [2:0] PH_START        = 3'd0;
  localparam logic [2:0] PH_SIGNED       = 3'd1;
  localparam logic [2:0] PH_LEAD_ZERO    = 3'd2;
  localparam logic [2:0] PH_DIGITS       = 3'd3;
  localparam logic [2:0] PH_AFTER_PREFIX = 3'd4;

  localparam logic [5:0] NOT_DIGIT = 6'h3F;

  // configuration
  stoi_pkg::radix_t radix_r;
  stoi_pkg::kind_t  kind_r;

  // input register
  logic          in_v_r;
  stoi_pkg::ch_t in_ch_r;

  // parse state
  stoi_pkg::value_t mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic             seen_r, seen_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bad_r, bad_nxt;

  // output register
  logic              out_v_r, out_v_nxt;
  stoi_pkg::value_t  out_val_r, out_val_nxt;
  stoi_pkg::status_t out_st_r, out_st_nxt;

  logic       is_term;
  logic       go;
  logic [5:0] dig;
  logic       dig_ok;
  logic [70:0] prod;
  logic       over;
  logic       kind_neg_bad;

  assign cfg_chan.ready = 1'b1;

  assign is_term = (in_ch_r == stoi_pkg::CH_NUL);
  // a terminator needs a free output slot, anything else always moves on
  assign go = in_v_r && (!is_term || !out_v_r || out_chan.ready);
  assign in_chan.ready = !in_v_r || go;

  assign out_chan.valid        = out_v_r;
  assign out_chan.parsed_value = out_val_r;
  assign out_chan.status       = out_st_r;

  // digit decode, letters 10..35 in either case
  always_comb begin
    dig = NOT_DIGIT;
    if (in_ch_r inside {[stoi_pkg::CH_ZERO:stoi_pkg::CH_NINE]}) begin
      dig = 6'(in_ch_r - stoi_pkg::CH_ZERO);
    end else if (in_ch_r inside {[stoi_pkg::CH_LA:stoi_pkg::CH_LZ]}) begin
      dig = 6'(in_ch_r - stoi_pkg::CH_LA + 8'd10);
    end else if (in_ch_r inside {[stoi_pkg::CH_UA:stoi_pkg::CH_UZ]}) begin
      dig = 6'(in_ch_r - stoi_pkg::CH_UA + 8'd10);
    end
    dig_ok = (dig != NOT_DIGIT) && (radix_r >= 6'd2) && (radix_r <= 6'd36)
             && (dig < radix_r);
  end

  // multiply-accumulate; any bit from 64 up means the value no longer fits
  assign prod = 71'(mag_r) * 71'(radix_r) + 71'(dig);

  // range check for the kind sampled at the terminator
  always_comb begin
    over = ovf_r;
    case (kind_r)
      stoi_pkg::KIND_S32: over = ovf_r || (mag_r > (neg_r ? 64'h8000_0000 : 64'h7FFF_FFFF));
      stoi_pkg::KIND_S64: over = ovf_r || (mag_r > (neg_r ? 64'h8000_0000_0000_0000
                                                          : 64'h7FFF_FFFF_FFFF_FFFF));
      stoi_pkg::KIND_U32: over = ovf_r || (mag_r > 64'hFFFF_FFFF);
      default:            over = ovf_r;
    endcase
  end

  // minus sign is not allowed for unsigned kinds
  assign kind_neg_bad = neg_r && kind_r[1];

  always_comb begin
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    bad_nxt   = bad_r;

    out_v_nxt   = out_v_r && !out_chan.ready;
    out_val_nxt = out_val_r;
    out_st_nxt  = out_st_r;

    if (go) begin
      if (is_term) begin
        // malformed wins over out of range
        out_v_nxt = 1'b1;
        if (bad_r || !seen_r || kind_neg_bad) begin
          out_st_nxt  = stoi_pkg::ST_MALFORMED;
          out_val_nxt = '0;
        end else if (over) begin
          out_st_nxt  = stoi_pkg::ST_RANGE;
          out_val_nxt = '0;
        end else begin
          out_st_nxt  = stoi_pkg::ST_OK;
          out_val_nxt = neg_r ? (64'd0 - mag_r) : mag_r;
        end
        // rearm for the next string
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_START;
        seen_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
        bad_nxt   = 1'b0;
      end else if (!bad_r) begin
        if (phase_r == PH_START && (in_ch_r inside {stoi_pkg::CH_PLUS, stoi_pkg::CH_MINUS})) begin
          neg_nxt   = (in_ch_r == stoi_pkg::CH_MINUS);
          phase_nxt = PH_SIGNED;
        end else if (phase_r == PH_LEAD_ZERO && radix_r == 6'd16 &&
                     (in_ch_r inside {stoi_pkg::CH_LX, stoi_pkg::CH_UX})) begin
          // hex prefix, digits must follow
          phase_nxt = PH_AFTER_PREFIX;
          seen_nxt  = 1'b0;
        end else if (!dig_ok) begin
          bad_nxt = 1'b1;
        end else begin
          if (!ovf_r) begin
            if (prod[70:64] != 7'd0) begin
              ovf_nxt = 1'b1;
              mag_nxt = '1;
            end else begin
              mag_nxt = prod[63:0];
            end
          end
          seen_nxt = 1'b1;
          if ((phase_r == PH_START || phase_r == PH_SIGNED) && dig == 6'd0) begin
            phase_nxt = PH_LEAD_ZERO;
          end else begin
            phase_nxt = PH_DIGITS;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= stoi_pkg::RADIX_RESET;
      kind_r  <= stoi_pkg::KIND_RESET;
      in_v_r  <= 1'b0;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= PH_START;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      bad_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        case (cfg_chan.idx)
          stoi_pkg::REG_RADIX: radix_r <= cfg_chan.data[stoi_pkg::RADIX_W-1:0];
          stoi_pkg::REG_KIND:  kind_r  <= cfg_chan.data[stoi_pkg::KIND_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.ready) begin
        in_v_r <= in_chan.valid;
      end
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      bad_r   <= bad_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_ch_r <= in_chan.ch;
    end
    out_val_r <= out_val_nxt;
    out_st_r  <= out_st_nxt;
  end

endmodule

[verif/stoi_parse_checker.sv]
// checker for the string-to-integer parser: predicts each result word and compares it
module stoi_parse_checker
  import stoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  stoi_in_if          in_mon,
  stoi_out_if         out_mon,
  stoi_cfg_if         cfg_mon,
  output int unsigned mismatches,
  output int unsigned outstanding,
  output int unsigned n_ok,
  output int unsigned n_malformed,
  output int unsigned n_range
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_SIGNED,
    SCAN_LEAD_ZERO,
    SCAN_DIGITS,
    SCAN_AFTER_PREFIX
  } scan_e;

  typedef struct packed {
    value_t  value;
    status_t status;
  } parse_result_t;

  localparam int unsigned NO_DIGIT = 255;

  radix_t radix_q;
  kind_t  kind_q;

  value_t mag;
  logic   neg;
  scan_e  scan;
  logic   seen;
  logic   ovf;
  logic   bad;

  parse_result_t expected_q[$];

  function automatic void clear_parse();
    mag  = '0;
    neg  = 1'b0;
    scan = SCAN_START;
    seen = 1'b0;
    ovf  = 1'b0;
    bad  = 1'b0;
  endfunction

  // one character through the parser; a terminator yields a result word
  function automatic void parse_char(input ch_t c, output bit fired, output parse_result_t res);
    int unsigned d;
    logic        over;
    logic [71:0] acc;
    fired      = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (c == CH_NUL) begin
      fired = 1'b1;
      if (bad || !seen || (neg && (kind_q == KIND_U32 || kind_q == KIND_U64))) begin
        res.status = ST_MALFORMED;
      end else begin
        over = ovf;
        case (kind_q)
          KIND_S32: over = over || mag > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
          KIND_S64: over = over || mag > (neg ? 64'h8000_0000_0000_0000
                                              : 64'h7FFF_FFFF_FFFF_FFFF);
          KIND_U32: over = over || mag > 64'hFFFF_FFFF;
          default: ;
        endcase
        if (over) res.status = ST_RANGE;
        else res.value = neg ? value_t'(0) - mag : mag;
      end
      clear_parse();
    end else if (!bad) begin
      if (scan == SCAN_START && (c == CH_PLUS || c == CH_MINUS)) begin
        neg  = (c == CH_MINUS);
        scan = SCAN_SIGNED;
      end else if (scan == SCAN_LEAD_ZERO && radix_q == 16 && (c == CH_LX || c == CH_UX)) begin
        scan = SCAN_AFTER_PREFIX;
        seen = 1'b0;
      end else begin
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
        else if (c >= CH_LA && c <= CH_LZ) d = c - CH_LA + 10;
        else if (c >= CH_UA && c <= CH_UZ) d = c - CH_UA + 10;
        if (radix_q < 2 || radix_q > 36 || d >= radix_q) begin
          bad = 1'b1;
        end else begin
          // saturate once the running value leaves 64 bits
          if (!ovf) begin
            acc = 72'(mag) * radix_q + d;
            if (acc[71:64] != 0) begin
              ovf = 1'b1;
              mag = '1;
            end else begin
              mag = acc[63:0];
            end
          end
          seen = 1'b1;
          scan = ((scan == SCAN_START || scan == SCAN_SIGNED) && d == 0) ? SCAN_LEAD_ZERO
                                                                         : SCAN_DIGITS;
        end
      end
    end
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    bit            fired;
    parse_result_t res;
    parse_result_t want;
    if (!rst_n) begin
      radix_q = RADIX_RESET;
      kind_q  = KIND_RESET;
      clear_parse();
      expected_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.idx == REG_RADIX) radix_q = cfg_mon.data[RADIX_W-1:0];
        else if (cfg_mon.idx == REG_KIND) kind_q = cfg_mon.data[KIND_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        parse_char(in_mon.ch, fired, res);
        if (fired) expected_q.push_back(res);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          note_failure($sformatf("%0t: unexpected result word, value %h status %0d",
                                 $time, out_mon.parsed_value, out_mon.status));
        end else begin
          want = expected_q.pop_front();
          case (want.status)
            ST_OK:        n_ok++;
            ST_MALFORMED: n_malformed++;
            default:      n_range++;
          endcase
          if (out_mon.parsed_value !== want.value || out_mon.status !== want.status) begin
            note_failure($sformatf(
              "%0t: mismatch, expected value %h status %0d, got value %h status %0d",
              $time, want.value, want.status, out_mon.parsed_value, out_mon.status));
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

[verif/tb_string_to_integer_parser.sv]
// testbench top for the string-to-integer parser: clock, reset, stimulus and verdict
module tb_string_to_integer_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import stoi_pkg::*;

  // idle odds in percent, on both the character and result sides
  localparam int unsigned IDLE_PCT    = 9;
  // receiver hold-off long enough to back the parser up into its input
  localparam int unsigned HOLD_CYCLES = 300;
  // characters per radix/kind setting in the random part
  localparam int unsigned PHASE_CHARS = 45;
  localparam int unsigned N_PLAN      = 15;

  localparam ch_t CH_SPACE = 8'h20;
  localparam ch_t CH_TAB   = 8'h09;
  localparam ch_t CH_LF    = 8'h0A;

  // radix/kind settings walked by the random part; invalid radices included
  localparam radix_t PLAN_RADIX [N_PLAN] = '{
    6'd10, 6'd2, 6'd36, 6'd16, 6'd8, 6'd0, 6'd16, 6'd37,
    6'd1, 6'd63, 6'd3, 6'd10, 6'd36, 6'd16, 6'd2
  };
  localparam kind_t PLAN_KIND [N_PLAN] = '{
    KIND_S32, KIND_U64, KIND_S64, KIND_U32, KIND_S32, KIND_S64, KIND_S64, KIND_U32,
    KIND_U64, KIND_S32, KIND_U64, KIND_U32, KIND_U64, KIND_S32, KIND_S32
  };

  // magnitudes on both sides of the 32-bit and signed 64-bit limits, up to the u64 maximum
  localparam value_t LIMIT_MAGS [11] = '{
    64'h0, 64'h1, 64'h7FFF_FFFF, 64'h8000_0000, 64'h8000_0001, 64'hFFFF_FFFF,
    64'h1_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF
  };

  logic clk = 1'b0;
  logic rst_n;

  stoi_in_if  in_chan();
  stoi_out_if out_chan();
  stoi_cfg_if cfg_chan();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_ok;
  int unsigned n_malformed;
  int unsigned n_range;

  // shadow of the registers, used only to shape the strings
  radix_t cur_radix;
  kind_t  cur_kind;

  bit          calm;        // no idling on either side while set
  bit          hold_req;    // asks the receiver for one long hold-off
  int unsigned hold_left;
  int unsigned chars_sent;
  int unsigned settings_done;
  ch_t         text_q[$];   // string being built, terminator included when it has one

  string_to_integer_parser uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  stoi_parse_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_mon     (cfg_chan),
    .mismatches  (fail_count),
    .outstanding (pending),
    .n_ok        (n_ok),
    .n_malformed (n_malformed),
    .n_range     (n_range)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready = 1'b0;
      end else begin
        out_chan.ready = calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic bit radix_ok();
    return cur_radix >= 2 && cur_radix <= 36;
  endfunction

  // digit character for a value, letters in either case
  function automatic ch_t digit_char(input int unsigned v);
    if (v < 10) return CH_ZERO + ch_t'(v);
    if ($urandom_range(1)) return CH_LA + ch_t'(v - 10);
    return CH_UA + ch_t'(v - 10);
  endfunction

  // offer one character word, entered and left at a falling edge; valid stays
  // high afterwards so back-to-back words need no extra assignment
  task automatic put_char(input ch_t c);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid = 1'b0;
      in_chan.ch    = ch_t'($urandom);
      @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.ch    = c;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[k]) put_char(text_q[k]);
  endtask

  task automatic send_literal(input string s, input bit terminate);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(ch_t'(s[i]));
    if (terminate) text_q.push_back(CH_NUL);
    send_text();
  endtask

  // digits of a magnitude in the current radix, most significant first
  task automatic append_value(input value_t m);
    ch_t digs[$];
    do begin
      digs.push_front(digit_char(32'(m % cur_radix)));
      m = m / cur_radix;
    end while (m != 0);
    foreach (digs[i]) text_q.push_back(digs[i]);
  endtask

  // wait until every result is in and the pipeline has drained, then write
  // both registers; a partly sent string may stay open across the write
  task automatic write_settings(input radix_t r, input kind_t k);
    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.idx   = REG_RADIX;
    cfg_chan.data  = {2'($urandom_range(3)), r};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.idx  = REG_KIND;
    cfg_chan.data = {6'($urandom), k};
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
    cur_radix = r;
    cur_kind  = k;
    settings_done++;
  endtask

  // one random string: mostly well-formed numbers, some near the kind limits,
  // the rest broken by noise, stray signs, whitespace, truncation or a bare prefix
  task automatic compose_string();
    int unsigned sel;
    int unsigned span;
    int unsigned len;
    int unsigned pos;
    sel  = $urandom_range(99);
    span = radix_ok() ? cur_radix : 36;
    text_q.delete();
    case ($urandom_range(3))
      0: text_q.push_back(CH_PLUS);
      1: text_q.push_back(CH_MINUS);
      default: ;
    endcase
    if (cur_radix == 16 && $urandom_range(2) == 0) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
    end
    if (sel < 20 && radix_ok()) begin
      append_value(LIMIT_MAGS[$urandom_range(10)]);
      // one more digit pushes the largest limits past 64 bits
      if ($urandom_range(3) == 0) text_q.push_back(digit_char($urandom_range(span - 1)));
    end else begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 20) : $urandom_range(8, 1);
      repeat (len) text_q.push_back(digit_char($urandom_range(span - 1)));
    end
    if (sel >= 75) begin
      pos = $urandom_range(text_q.size());
      case ($urandom_range(4))
        0: text_q.insert(pos, ch_t'($urandom_range(255, 1)));
        1: text_q.insert(pos, $urandom_range(1) ? CH_PLUS : CH_MINUS);
        2: begin
          // empty string or a single leading character
          len = $urandom_range(1);
          while (text_q.size() > len) void'(text_q.pop_back());
        end
        3: begin
          case ($urandom_range(2))
            0: text_q.insert(pos, CH_SPACE);
            1: text_q.insert(pos, CH_TAB);
            default: text_q.insert(pos, CH_LF);
          endcase
        end
        default: begin
          // prefix with nothing after it
          text_q.delete();
          if ($urandom_range(1)) text_q.push_back(CH_MINUS);
          text_q.push_back(CH_ZERO);
          text_q.push_back($urandom_range(1) ? CH_LX : CH_UX);
        end
      endcase
    end
    text_q.push_back(CH_NUL);
  endtask

  initial begin
    int unsigned start;
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.ch     = CH_NUL;
    cfg_chan.valid = 1'b0;
    cfg_chan.idx   = REG_RADIX;
    cfg_chan.data  = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    cur_radix      = RADIX_RESET;
    cur_kind       = KIND_RESET;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, decimal signed 64
    send_literal("", 1'b1);     // empty string
    send_literal("-", 1'b1);    // sign with no digits
    send_literal(" 5", 1'b1);   // leading whitespace
    send_literal("+-3", 1'b1);  // two signs
    send_literal("4-", 1'b1);   // sign after digits
    send_literal("+1", 1'b0);   // left open across the register write
    write_settings(6'd16, KIND_U32);
    send_literal("f", 1'b1);    // finishes the open string in base 16
    send_literal("0x", 1'b1);   // prefix with no hex digit
    send_literal("-0", 1'b1);   // minus with an unsigned kind
    send_literal("0Xf", 1'b1);  // upper-case prefix

    // random part, one stretch per setting
    for (int i = 0; i < N_PLAN; i++) begin
      write_settings(PLAN_RADIX[i], PLAN_KIND[i]);
      calm = (i == 5);
      if (i == 3) hold_req = 1'b1;
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) begin
        compose_string();
        send_text();
      end
    end
    calm = 1'b0;

    in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d characters over %0d radix/kind settings", chars_sent,
             settings_done);
    $display("result words checked: %0d ok, %0d malformed, %0d out of range",
             n_ok, n_malformed, n_range);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/stoi_pkg.sv
sv/stoi_if.sv
sv/string_to_integer_parser.sv
verif/stoi_parse_checker.sv
verif/tb_string_to_integer_parser.sv
